// ===== src/fas_pkg.sv =====
// ----------------------------------------------------------------------------
// fas_pkg
// Types and constants shared by the frame animation sequencer files.
// ----------------------------------------------------------------------------
package fas_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ENTRY_W    = 6;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned DELTA_W    = 16;
  localparam int unsigned FRAME_W    = 6;
  localparam int unsigned FCOUNT_W   = 7;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned LOOP_W     = 16;
  localparam int unsigned ACC_W      = 40;
  localparam int unsigned PROD_W     = DELTA_W + SPEED_W;

  // Register indexes (word address paddr[3:2])
  typedef enum logic [1:0] {
    REG_FRAME_COUNT = 2'd0,
    REG_SPEED       = 2'd1,
    REG_LOOP_LIMIT  = 2'd2
  } reg_idx_e;

  // Reset values of the configuration registers
  localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST = 7'd1;
  localparam logic [SPEED_W-1:0]  SPEED_RST       = 16'd256;
  localparam logic [LOOP_W-1:0]   LOOP_LIMIT_RST  = 16'd0;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CHECK,
    S_WAIT,
    S_DONE
  } state_e;

  // Input beat
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ENTRY_W-1:0] entry_index;
    logic [DELAY_W-1:0] delay_ms;
    logic [DELTA_W-1:0] time_delta;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic               loop_done;
    logic               step_capped;
  } out_beat_t;

endpackage

// ===== src/fas_stream_if.sv =====
// ----------------------------------------------------------------------------
// fas_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface fas_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/fas_ram.sv =====
// ----------------------------------------------------------------------------
// fas_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fas_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/frame_animation_sequencer.sv =====
// ----------------------------------------------------------------------------
// frame_animation_sequencer
// Timed frame sequencer with per-frame delay table and loop count.
// ----------------------------------------------------------------------------
// One item is in flight at a time. For a delay write, a restart or an unused
// command, the block moves from S_IDLE to S_DONE at the accepting edge, and
// the result beat is loaded into the output register from S_DONE as soon as
// the output register is free.
// For a tick, the block steps through S_ADD and S_CHECK, then through S_WAIT
// and S_CHECK once for each of the k frame advances it makes (0..MAX_STEPS),
// and then to S_DONE. Each advance needs a fresh read of the current frame's
// delay from the delay RAM. The RAM read is registered, so the compare/advance
// loop passes through S_WAIT between two checks.
// The next item is taken as soon as the result sits in the output register,
// even if it has not been taken yet. The delay RAM is not cleared after
// reset; frames must be written before they are played. The user must write
// configuration over the APB-style port only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module frame_animation_sequencer
  import fas_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 64,
  parameter int unsigned MAX_STEPS  = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fas_stream_if.sink            in_i,
  fas_stream_if.source          out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned NW = (FW + 1 > FCOUNT_W) ? FW + 1 : FCOUNT_W;
  localparam int unsigned SW = $clog2(MAX_STEPS + 1);

  // state
  state_e               state_q, state_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [FW-1:0]        cur_q, cur_d;
  logic [LOOP_W-1:0]    loops_q, loops_d;
  logic                 fin_q, fin_d;
  logic [SW-1:0]        steps_q, steps_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic                 done_q, done_d;
  logic                 capped_q, capped_d;
  logic [FCOUNT_W-1:0]  frame_count_q, frame_count_d;
  logic [SPEED_W-1:0]   speed_q, speed_d;
  logic [LOOP_W-1:0]    loop_limit_q, loop_limit_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_data_q, out_data_d;

  // handshakes
  logic                 in_fire;
  logic                 cfg_wr;
  logic                 out_free;
  logic                 out_load;
  cmd_e                 in_cmd;

  // delay RAM
  logic                 ram_we;
  logic [FW-1:0]        ram_waddr;
  logic [DELAY_W-1:0]   ram_rdata;
  logic                 entry_ok;

  // advance datapath
  logic [NW-1:0]        n_used;
  logic [FW-1:0]        last;
  logic [ACC_W-1:0]     need;
  logic [ACC_W:0]       acc_sum;
  logic                 step_go;

  assign in_fire  = in_i.valid & in_i.ready;
  assign cfg_wr   = psel & penable & pwrite;
  assign out_free = ~out_valid_q | out_o.ready;
  assign in_cmd   = cmd_e'(in_i.data.cmd);
  assign pready   = 1'b1;

  // frames in use, clamped to 1..MAX_FRAMES
  always_comb begin
    n_used = NW'(frame_count_q);
    if (n_used == '0) begin
      n_used = NW'(1);
    end
    if (n_used > NW'(MAX_FRAMES)) begin
      n_used = NW'(MAX_FRAMES);
    end
  end
  assign last = FW'(n_used - NW'(1));

  // delay of the current frame in accumulator units
  assign need    = ACC_W'({ram_rdata, 16'h0000});
  assign acc_sum = {1'b0, acc_q} + (ACC_W + 1)'(prod_q);
  assign step_go = ~fin_q && (acc_q >= need) && (steps_q != SW'(MAX_STEPS));

  // delay table
  assign entry_ok  = NW'(in_i.data.entry_index) < NW'(MAX_FRAMES);
  assign ram_waddr = FW'(in_i.data.entry_index);
  assign ram_we    = in_fire && (in_cmd == CMD_WRITE) && entry_ok;

  fas_ram #(
    .WIDTH (DELAY_W),
    .DEPTH (MAX_FRAMES)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.data.delay_ms),
    .raddr_i (cur_q),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_cmd == CMD_TICK) ? S_ADD : S_DONE;
        end
      end
      S_ADD:   state_d = S_CHECK;
      S_CHECK: state_d = step_go ? S_WAIT : S_DONE;
      S_WAIT:  state_d = S_CHECK;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state machine outputs
  always_comb begin
    in_i.ready = (state_q == S_IDLE);
    out_load   = (state_q == S_DONE) && out_free;
  end

  // sequencer datapath
  always_comb begin
    acc_d         = acc_q;
    cur_d         = cur_q;
    loops_d       = loops_q;
    fin_d         = fin_q;
    steps_d       = steps_q;
    prod_d        = prod_q;
    done_d        = done_q;
    capped_d      = capped_q;
    frame_count_d = frame_count_q;
    speed_d       = speed_q;
    loop_limit_d  = loop_limit_q;

    // register writes
    if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_FRAME_COUNT: frame_count_d = pwdata[FCOUNT_W-1:0];
        REG_SPEED:       speed_d       = pwdata[SPEED_W-1:0];
        REG_LOOP_LIMIT: begin
          loop_limit_d = pwdata[LOOP_W-1:0];
          loops_d      = pwdata[LOOP_W-1:0];
          fin_d        = 1'b0;
        end
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          done_d   = 1'b0;
          capped_d = 1'b0;
          steps_d  = '0;
          case (in_cmd)
            CMD_TICK: prod_d = PROD_W'(in_i.data.time_delta) * PROD_W'(speed_q);
            CMD_RESTART: begin
              acc_d   = '0;
              cur_d   = '0;
              loops_d = loop_limit_q;
              fin_d   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      // saturating add of the scaled tick
      S_ADD: begin
        acc_d = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
      end
      // one advance per check while the accumulator covers the delay
      S_CHECK: begin
        if (!fin_q && (acc_q >= need) && (steps_q == SW'(MAX_STEPS))) begin
          capped_d = 1'b1;
        end
        if (step_go) begin
          steps_d = steps_q + SW'(1);
          acc_d   = acc_q - need;
          if (cur_q < last) begin
            cur_d = cur_q + FW'(1);
          end else if (loops_q == '0) begin
            cur_d  = '0;
            done_d = 1'b1;
          end else if (loops_q >= LOOP_W'(2)) begin
            loops_d = loops_q - LOOP_W'(1);
            cur_d   = '0;
            done_d  = 1'b1;
          end else begin
            loops_d = '0;
            fin_d   = 1'b1;
            cur_d   = last;
            acc_d   = '0;
            done_d  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d            = 1'b1;
      out_data_d.frame_index = FRAME_W'(cur_q);
      out_data_d.loop_done   = done_q;
      out_data_d.step_capped = capped_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // register read-back
  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_FRAME_COUNT: prdata = CFG_DATA_W'(frame_count_q);
      REG_SPEED:       prdata = CFG_DATA_W'(speed_q);
      REG_LOOP_LIMIT:  prdata = CFG_DATA_W'(loop_limit_q);
      default:         prdata = '0;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      acc_q         <= '0;
      cur_q         <= '0;
      loops_q       <= LOOP_LIMIT_RST;
      fin_q         <= 1'b0;
      steps_q       <= '0;
      done_q        <= 1'b0;
      capped_q      <= 1'b0;
      frame_count_q <= FRAME_COUNT_RST;
      speed_q       <= SPEED_RST;
      loop_limit_q  <= LOOP_LIMIT_RST;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      acc_q         <= acc_d;
      cur_q         <= cur_d;
      loops_q       <= loops_d;
      fin_q         <= fin_d;
      steps_q       <= steps_d;
      done_q        <= done_d;
      capped_q      <= capped_d;
      frame_count_q <= frame_count_d;
      speed_q       <= speed_d;
      loop_limit_q  <= loop_limit_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    out_data_q <= out_data_d;
  end

  // checks
  a_steps_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= SW'(MAX_STEPS))
    else $error("advance count passed the step cap");

  a_fin_loops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> (loops_q == '0))
    else $error("finished with loops still left");

  a_frame_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW'(cur_q) < NW'(MAX_FRAMES))
    else $error("current frame outside the delay table");

  a_out_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result beat loaded outside the done state");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("sequencer idle right after taking a beat");

endmodule
